// File: design/lgkf_pkg.sv
// Shared types, constants and fixed-point helpers for the latent growth Kalman filter.
`timescale 1ns / 1ps
`default_nettype none

package lgkf_pkg;

  // Sizing of the time index and the per-time-point response accumulators.
  localparam int MAX_TIMES = 1024;
  localparam int MAX_ITEMS = 64;
  localparam int TCAP      = ((MAX_TIMES - 1) < 1023) ? (MAX_TIMES - 1) : 1023;
  localparam int TIME_W    = 10;
  localparam int ICNT_W    = $clog2(MAX_ITEMS + 1);
  localparam int RQ_W      = 48;
  localparam int ACC_W     = RQ_W + 1 + $clog2(MAX_ITEMS);

  // Gain divider widths: numerator below 2^48, denominator below 2^47.
  localparam int NUM_W     = 48;
  localparam int DEN_W     = 47;
  localparam int DCNT_W    = $clog2(NUM_W);

  // Configuration port.
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR  = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET_VAL = 31'd65536;

  // One in Q16.16.
  localparam int Q_ONE = 65536;

  typedef logic signed [63:0]       wide_t;
  typedef logic signed [RQ_W-1:0]   rq_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [31:0]       q32_t;
  typedef logic [30:0]              u31_t;
  typedef logic [TIME_W-1:0]        time_t;
  typedef logic [ICNT_W-1:0]        icnt_t;

  typedef struct packed {
    logic signed [31:0] response;
    logic signed [31:0] item_disc;
    logic signed [31:0] item_diff;
    logic               time_end;
    logic               person_start;
    logic signed [31:0] trend_intercept;
    logic signed [31:0] trend_slope;
    logic signed [31:0] autoreg_coef;
    logic signed [31:0] init_mean;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] post_mean;
    logic [30:0]        post_var;
    logic signed [31:0] prior_mean;
    logic [30:0]        prior_var;
    logic [TIME_W-1:0]  time_index;
  } out_item_t;

  // Round a Q32.32 product to Q32.16: add half an LSB, then floor.
  function automatic rq_t rq(input wide_t p);
    wide_t t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic q32_t sat32(input wide_t x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Clamp to 0 .. 2^31-1.
  function automatic u31_t sat31(input wide_t x);
    if (x > 64'sd2147483647) begin
      return 31'h7FFFFFFF;
    end
    if (x < 64'sd0) begin
      return 31'd0;
    end
    return x[30:0];
  endfunction

endpackage

`default_nettype wire

// File: design/lgkf_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
`timescale 1ns / 1ps
`default_nettype none

module lgkf_mul (
  input  wire logic                 clk,
  input  wire lgkf_pkg::q32_t       mul_a,
  input  wire lgkf_pkg::q32_t       mul_b,
  output lgkf_pkg::wide_t           prod
);

  lgkf_pkg::wide_t prod_r;

  // The product is registered, so it is available in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    prod_r <= lgkf_pkg::wide_t'(mul_a) * lgkf_pkg::wide_t'(mul_b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// File: design/lgkf_div.sv
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
`timescale 1ns / 1ps
`default_nettype none

module lgkf_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lgkf_pkg::NUM_W-1:0] num,
  input  wire logic [lgkf_pkg::DEN_W-1:0] den,
  output logic                            done,
  output logic [lgkf_pkg::NUM_W-1:0]      quo
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [lgkf_pkg::DCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [lgkf_pkg::NUM_W-1:0]      rem_r, rem_nxt;
  logic [lgkf_pkg::NUM_W-1:0]      quo_r, quo_nxt;
  logic [lgkf_pkg::NUM_W-1:0]      den_r, den_nxt;
  logic [lgkf_pkg::NUM_W-1:0]      trial;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign trial = {rem_r[lgkf_pkg::NUM_W-2:0], quo_r[lgkf_pkg::NUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = {1'b0, den};
    end else if (busy_r) begin
      // Shift one numerator bit into the remainder and try a subtract.
      if (trial >= den_r) begin
        rem_nxt = trial - den_r;
        quo_nxt = {quo_r[lgkf_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[lgkf_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lgkf_pkg::DCNT_W'(lgkf_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// File: design/latent_growth_kalman_filter.sv
// Top level of the scalar-state Kalman filter for a latent growth model.
`timescale 1ns / 1ps
`default_nettype none

// Each input item is one item response; the block holds in_stall high while it works
// on it and takes one item at a time. A response is accumulated by the accept step and
// states S_ACC1 to S_ACC4 (three products through the single shared 32x32 multiplier).
// An item with time_end set then runs S_P1 to S_P6 and S_FIN at time zero of a person,
// plus, at later time points, S_P7 to S_P11 and the 48-step restoring divider for the gain.
// Results leave through an output register, so a waiting result does not block the
// next response. No clearing pass is needed after reset.
module latent_growth_kalman_filter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire lgkf_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output lgkf_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [lgkf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [lgkf_pkg::CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_ACC1, S_ACC2, S_ACC3, S_ACC4,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
    S_P7, S_P8, S_P9, S_DIV, S_P10, S_P11, S_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [lgkf_pkg::CFG_W-1:0]      noise_var_r, noise_var_nxt;
  logic [lgkf_pkg::CFG_W-1:0]      init_var_r, init_var_nxt;
  lgkf_pkg::q32_t                  held_icpt_r, held_icpt_nxt;
  lgkf_pkg::q32_t                  held_slope_r, held_slope_nxt;
  lgkf_pkg::q32_t                  held_ar_r, held_ar_nxt;
  lgkf_pkg::q32_t                  last_mean_r, last_mean_nxt;
  lgkf_pkg::u31_t                  last_var_r, last_var_nxt;
  lgkf_pkg::time_t                 time_cnt_r, time_cnt_nxt;
  lgkf_pkg::icnt_t                 item_cnt_r, item_cnt_nxt;
  lgkf_pkg::acc_t                  sum_resp_r, sum_resp_nxt;
  lgkf_pkg::acc_t                  sum_sq_r, sum_sq_nxt;
  lgkf_pkg::acc_t                  sum_diff_r, sum_diff_nxt;
  lgkf_pkg::q32_t                  z_r, z_nxt;
  lgkf_pkg::q32_t                  a_r, a_nxt;
  lgkf_pkg::q32_t                  b_r, b_nxt;
  logic                            tend_r, tend_nxt;
  logic signed [42:0]              trend_r, trend_nxt;
  lgkf_pkg::q32_t                  am_r, am_nxt;
  lgkf_pkg::u31_t                  b2_r, b2_nxt;
  lgkf_pkg::u31_t                  rv_r, rv_nxt;
  lgkf_pkg::u31_t                  s_r, s_nxt;
  logic [lgkf_pkg::DEN_W-1:0]      den_r, den_nxt;
  lgkf_pkg::q32_t                  e_r, e_nxt;
  lgkf_pkg::u31_t                  k_r, k_nxt;
  lgkf_pkg::out_item_t             out_r, out_nxt;
  logic                            out_valid_r, out_valid_nxt;

  lgkf_pkg::q32_t                  mul_a, mul_b;
  lgkf_pkg::wide_t                 prod;
  lgkf_pkg::rq_t                   prod_rq;
  logic                            div_start;
  logic                            div_done;
  logic [lgkf_pkg::NUM_W-1:0]      div_num;
  logic [lgkf_pkg::NUM_W-1:0]      div_quo;
  lgkf_pkg::time_t                 t_eff;
  logic                            acc_ok;
  logic                            in_acc;

  lgkf_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  lgkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign prod_rq   = lgkf_pkg::rq(prod);

  // Time zero predicts with t = 1; later time points use their own index.
  assign t_eff = (time_cnt_r == '0) ? lgkf_pkg::time_t'(1) : time_cnt_r;

  // Responses beyond the per-time-point limit are dropped.
  assign acc_ok = in_data.person_start ||
                  (item_cnt_r < lgkf_pkg::icnt_t'(lgkf_pkg::MAX_ITEMS));

  // Gain numerator: r in Q16.32 plus half the divisor for rounding.
  assign div_num   = {1'b0, rv_r, 16'd0} + {2'b00, den_r[lgkf_pkg::DEN_W-1:1]};
  assign div_start = (state_r == S_P9);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_ACC1: begin
        mul_a = a_r;
        mul_b = z_r;
      end
      S_ACC2: begin
        mul_a = a_r;
        mul_b = a_r;
      end
      S_ACC3: begin
        mul_a = a_r;
        mul_b = b_r;
      end
      S_P1: begin
        mul_a = held_slope_r;
        mul_b = lgkf_pkg::q32_t'(t_eff);
      end
      S_P2: begin
        mul_a = held_ar_r;
        mul_b = last_mean_r;
      end
      S_P3: begin
        mul_a = held_ar_r;
        mul_b = held_ar_r;
      end
      S_P5: begin
        mul_a = {1'b0, b2_r};
        mul_b = {1'b0, last_var_r};
      end
      S_P7: begin
        mul_a = {1'b0, rv_r};
        mul_b = {1'b0, s_r};
      end
      S_P8: begin
        mul_a = am_r;
        mul_b = {1'b0, s_r};
      end
      S_P10: begin
        mul_a = {1'b0, k_r};
        mul_b = e_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer: accumulation of one response, then the predict and update steps.
  always_comb begin
    state_nxt      = state_r;
    noise_var_nxt  = noise_var_r;
    init_var_nxt   = init_var_r;
    held_icpt_nxt  = held_icpt_r;
    held_slope_nxt = held_slope_r;
    held_ar_nxt    = held_ar_r;
    last_mean_nxt  = last_mean_r;
    last_var_nxt   = last_var_r;
    time_cnt_nxt   = time_cnt_r;
    item_cnt_nxt   = item_cnt_r;
    sum_resp_nxt   = sum_resp_r;
    sum_sq_nxt     = sum_sq_r;
    sum_diff_nxt   = sum_diff_r;
    z_nxt          = z_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    tend_nxt       = tend_r;
    trend_nxt      = trend_r;
    am_nxt         = am_r;
    b2_nxt         = b2_r;
    rv_nxt         = rv_r;
    s_nxt          = s_r;
    den_nxt        = den_r;
    e_nxt          = e_r;
    k_nxt          = k_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    // The downstream side takes the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // The user must write the registers only while the block is idle; the block does not enforce it.
    if (cfg_we) begin
      case (cfg_idx)
        lgkf_pkg::CFG_NOISE_VAR: noise_var_nxt = cfg_wdata;
        lgkf_pkg::CFG_INIT_VAR:  init_var_nxt  = cfg_wdata;
        default: begin
          noise_var_nxt = noise_var_r;
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          z_nxt    = in_data.response;
          a_nxt    = in_data.item_disc;
          b_nxt    = in_data.item_diff;
          tend_nxt = in_data.time_end;
          // A new person restarts time and the sums.
          if (in_data.person_start) begin
            held_icpt_nxt  = in_data.trend_intercept;
            held_slope_nxt = in_data.trend_slope;
            held_ar_nxt    = in_data.autoreg_coef;
            last_mean_nxt  = in_data.init_mean;
            last_var_nxt   = init_var_r;
            time_cnt_nxt   = '0;
            item_cnt_nxt   = '0;
            sum_resp_nxt   = '0;
            sum_sq_nxt     = '0;
            sum_diff_nxt   = '0;
          end
          if (acc_ok) begin
            state_nxt = S_ACC1;
          end else if (in_data.time_end) begin
            state_nxt = S_P1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ACC1: begin
        state_nxt = S_ACC2;
      end
      S_ACC2: begin
        sum_resp_nxt = sum_resp_r + lgkf_pkg::acc_t'(prod_rq);
        state_nxt    = S_ACC3;
      end
      S_ACC3: begin
        sum_sq_nxt = sum_sq_r + lgkf_pkg::acc_t'(prod_rq);
        state_nxt  = S_ACC4;
      end
      S_ACC4: begin
        sum_diff_nxt = sum_diff_r + lgkf_pkg::acc_t'(prod_rq);
        item_cnt_nxt = item_cnt_r + 1'b1;
        state_nxt    = tend_r ? S_P1 : S_IDLE;
      end
      S_P1: begin
        state_nxt = S_P2;
      end
      S_P2: begin
        // Intercept plus slope times t.
        trend_nxt = 43'(held_icpt_r) + prod[42:0];
        state_nxt = S_P3;
      end
      S_P3: begin
        am_nxt    = lgkf_pkg::sat32(lgkf_pkg::wide_t'(trend_r) +
                                    lgkf_pkg::wide_t'(prod_rq));
        state_nxt = S_P4;
      end
      S_P4: begin
        b2_nxt    = lgkf_pkg::sat31(lgkf_pkg::wide_t'(prod_rq));
        state_nxt = S_P5;
      end
      S_P5: begin
        state_nxt = S_P6;
      end
      S_P6: begin
        rv_nxt    = lgkf_pkg::sat31(lgkf_pkg::wide_t'(prod_rq) +
                                    lgkf_pkg::wide_t'({33'd0, noise_var_r}));
        s_nxt     = lgkf_pkg::sat31(lgkf_pkg::wide_t'(sum_sq_r));
        state_nxt = (time_cnt_r == '0) ? S_FIN : S_P7;
      end
      S_P7: begin
        state_nxt = S_P8;
      end
      S_P8: begin
        // Gain divisor: one plus r times the sum of squared weights.
        den_nxt   = lgkf_pkg::DEN_W'(lgkf_pkg::wide_t'(prod_rq) +
                                     64'sd65536);
        state_nxt = S_P9;
      end
      S_P9: begin
        // Innovation from the accumulated sums and the predicted mean.
        e_nxt     = lgkf_pkg::sat32(
                      lgkf_pkg::wide_t'(lgkf_pkg::sat32(lgkf_pkg::wide_t'(sum_resp_r))) +
                      lgkf_pkg::wide_t'(lgkf_pkg::sat32(lgkf_pkg::wide_t'(sum_diff_r))) -
                      lgkf_pkg::wide_t'(prod_rq));
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          k_nxt     = div_quo[30:0];
          state_nxt = S_P10;
        end
      end
      S_P10: begin
        state_nxt = S_P11;
      end
      S_P11: begin
        last_mean_nxt = lgkf_pkg::sat32(lgkf_pkg::wide_t'(am_r) +
                                        lgkf_pkg::wide_t'(prod_rq));
        last_var_nxt  = k_r;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        // Load the result once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_nxt.post_mean  = last_mean_r;
          out_nxt.post_var   = last_var_r;
          out_nxt.prior_mean = am_r;
          out_nxt.prior_var  = rv_r;
          out_nxt.time_index = time_cnt_r;
          out_valid_nxt      = 1'b1;
          if (time_cnt_r < lgkf_pkg::time_t'(lgkf_pkg::TCAP)) begin
            time_cnt_nxt = time_cnt_r + 1'b1;
          end
          item_cnt_nxt = '0;
          sum_resp_nxt = '0;
          sum_sq_nxt   = '0;
          sum_diff_nxt = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, filter registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      noise_var_r  <= lgkf_pkg::CFG_RESET_VAL;
      init_var_r   <= lgkf_pkg::CFG_RESET_VAL;
      held_icpt_r  <= '0;
      held_slope_r <= '0;
      held_ar_r    <= '0;
      last_mean_r  <= '0;
      last_var_r   <= '0;
      time_cnt_r   <= '0;
      item_cnt_r   <= '0;
      sum_resp_r   <= '0;
      sum_sq_r     <= '0;
      sum_diff_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      noise_var_r  <= noise_var_nxt;
      init_var_r   <= init_var_nxt;
      held_icpt_r  <= held_icpt_nxt;
      held_slope_r <= held_slope_nxt;
      held_ar_r    <= held_ar_nxt;
      last_mean_r  <= last_mean_nxt;
      last_var_r   <= last_var_nxt;
      time_cnt_r   <= time_cnt_nxt;
      item_cnt_r   <= item_cnt_nxt;
      sum_resp_r   <= sum_resp_nxt;
      sum_sq_r     <= sum_sq_nxt;
      sum_diff_r   <= sum_diff_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    z_r     <= z_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    tend_r  <= tend_nxt;
    trend_r <= trend_nxt;
    am_r    <= am_nxt;
    b2_r    <= b2_nxt;
    rv_r    <= rv_nxt;
    s_r     <= s_nxt;
    den_r   <= den_nxt;
    e_r     <= e_nxt;
    k_r     <= k_nxt;
    out_r   <= out_nxt;
  end

endmodule

`default_nettype wire
